FILE: sv/tcs_pkg.sv
// Shared types and constants for the tagged chunk search block.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none
package tcs_pkg;

	localparam int unsigned HDR_BYTES = 8;
	localparam int unsigned ID_BYTES  = 4;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WANTED_ID   = 3'd0,
		CFG_FIRST_OFS   = 3'd1,
		CFG_SIZE_INCL   = 3'd2,
		CFG_SIZE_BIG    = 3'd3,
		CFG_STOP_ZERO   = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_FOUND     = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_ZERO_STOP = 2'd2,
		ST_MALFORMED = 2'd3
	} status_t;

	typedef enum logic {
		PH_HEADER = 1'b0,
		PH_SKIP   = 1'b1
	} phase_t;

	typedef struct packed {
		logic [31:0] wanted_id;
		logic [31:0] first_offset;
		logic        size_includes_header;
		logic        size_msb_first;
		logic        stop_on_zero_size;
	} cfg_t;

	typedef struct packed {
		logic        valid;
		status_t     status;
		logic [31:0] chunk_offset;
		logic [31:0] chunk_len;
	} result_t;

endpackage
`default_nettype wire

FILE: sv/tcs_cfg_regs.sv
// Configuration register file for the tagged chunk search block.
// Depends on tcs_pkg for the register indexes and the configuration struct.
`default_nettype none
module tcs_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [tcs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [tcs_pkg::CFG_DATA_W-1:0]   cfg_data,
	output tcs_pkg::cfg_t                         cfg
);

	tcs_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wanted_id            <= '0;
			cfg_q.first_offset         <= '0;
			cfg_q.size_includes_header <= 1'b0;
			cfg_q.size_msb_first       <= 1'b1;
			cfg_q.stop_on_zero_size    <= 1'b0;
		end else if (cfg_wr_en) begin
			case (tcs_pkg::cfg_idx_t'(cfg_index))
				tcs_pkg::CFG_WANTED_ID: cfg_q.wanted_id <= cfg_data;
				tcs_pkg::CFG_FIRST_OFS: cfg_q.first_offset <= cfg_data;
				tcs_pkg::CFG_SIZE_INCL: cfg_q.size_includes_header <= cfg_data[0];
				tcs_pkg::CFG_SIZE_BIG:  cfg_q.size_msb_first <= cfg_data[0];
				tcs_pkg::CFG_STOP_ZERO: cfg_q.stop_on_zero_size <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

FILE: sv/tcs_search.sv
// Search state and per-byte decision logic: header gathering, body skipping
// and result formation. Depends on tcs_pkg for types and constants.
`default_nettype none
module tcs_search (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire tcs_pkg::cfg_t cfg,
	input  wire logic        step,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_stream,
	output tcs_pkg::result_t res
);

	logic [31:0]      position_q;
	logic [63:0]      header_shift_q;
	logic [3:0]       header_count_q;
	logic [31:0]      skip_remaining_q;
	tcs_pkg::phase_t  phase_q;
	logic             done_q;

	logic [31:0]      position_d;
	logic [63:0]      header_shift_d;
	logic [3:0]       header_count_d;
	logic [31:0]      skip_remaining_d;
	tcs_pkg::phase_t  phase_d;
	logic             done_d;

	logic [63:0]      shift_new;
	logic [3:0]       count_new;
	logic [31:0]      hdr_id;
	logic [31:0]      hdr_raw;
	logic [31:0]      hdr_size;
	logic [31:0]      body_len;
	logic [31:0]      skip_dec;

	assign shift_new = {header_shift_q[55:0], data_byte};
	assign count_new = header_count_q + 4'd1;
	assign hdr_id    = shift_new[63:32];
	assign hdr_raw   = shift_new[31:0];
	assign hdr_size  = cfg.size_msb_first ? hdr_raw :
		{hdr_raw[7:0], hdr_raw[15:8], hdr_raw[23:16], hdr_raw[31:24]};
	assign body_len  = cfg.size_includes_header ?
		(hdr_size - 32'(tcs_pkg::HDR_BYTES)) : hdr_size;
	assign skip_dec  = skip_remaining_q - 32'd1;

	always_comb begin
		position_d       = position_q;
		header_shift_d   = header_shift_q;
		header_count_d   = header_count_q;
		skip_remaining_d = skip_remaining_q;
		phase_d          = phase_q;
		done_d           = done_q;
		res.valid        = 1'b0;
		res.status       = tcs_pkg::ST_NOT_FOUND;
		res.chunk_offset = '0;
		res.chunk_len    = '0;

		if (!done_q) begin
			if (phase_q == tcs_pkg::PH_SKIP) begin
				skip_remaining_d = skip_dec;
				if (skip_dec == 32'd0) begin
					phase_d        = tcs_pkg::PH_HEADER;
					header_count_d = '0;
					header_shift_d = '0;
				end
			end else begin
				header_shift_d = shift_new;
				header_count_d = count_new;
				if (count_new >= 4'(tcs_pkg::HDR_BYTES)) begin
					header_count_d = '0;
					header_shift_d = '0;
					if (hdr_id == cfg.wanted_id) begin
						res.valid        = 1'b1;
						res.status       = tcs_pkg::ST_FOUND;
						res.chunk_offset = cfg.first_offset + position_q + 32'd1;
						res.chunk_len    = hdr_size;
						done_d           = 1'b1;
					end else if (hdr_size == 32'd0 && cfg.stop_on_zero_size) begin
						res.valid  = 1'b1;
						res.status = tcs_pkg::ST_ZERO_STOP;
						done_d     = 1'b1;
					end else if (cfg.size_includes_header &&
						hdr_size < 32'(tcs_pkg::HDR_BYTES)) begin
						res.valid  = 1'b1;
						res.status = tcs_pkg::ST_MALFORMED;
						done_d     = 1'b1;
					end else begin
						skip_remaining_d = body_len;
						phase_d = (body_len != 32'd0) ? tcs_pkg::PH_SKIP :
							tcs_pkg::PH_HEADER;
					end
				end
			end
			position_d = position_q + 32'd1;
			if (end_of_stream && !res.valid) begin
				res.valid  = 1'b1;
				res.status = tcs_pkg::ST_NOT_FOUND;
			end
		end

		if (end_of_stream) begin
			position_d       = '0;
			header_shift_d   = '0;
			header_count_d   = '0;
			skip_remaining_d = '0;
			phase_d          = tcs_pkg::PH_HEADER;
			done_d           = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q       <= '0;
			header_shift_q   <= '0;
			header_count_q   <= '0;
			skip_remaining_q <= '0;
			phase_q          <= tcs_pkg::PH_HEADER;
			done_q           <= 1'b0;
		end else if (step) begin
			position_q       <= position_d;
			header_shift_q   <= header_shift_d;
			header_count_q   <= header_count_d;
			skip_remaining_q <= skip_remaining_d;
			phase_q          <= phase_d;
			done_q           <= done_d;
		end
	end

`ifndef SYNTHESIS
	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == tcs_pkg::PH_SKIP |-> skip_remaining_q != 32'd0)
		else $error("skip phase entered with nothing to skip");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		header_count_q < 4'(tcs_pkg::HDR_BYTES))
		else $error("header byte count ran past a full header");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status != tcs_pkg::ST_FOUND |->
			res.chunk_offset == 32'd0 && res.chunk_len == 32'd0)
		else $error("non-found result carries offset or size");

	a_eos_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && end_of_stream |=>
			position_q == 32'd0 && !done_q && header_count_q == 4'd0)
		else $error("search state not cleared after end of stream");
`endif

endmodule
`default_nettype wire

FILE: sv/tagged_chunk_search.sv
// Tagged chunk search: finds a chunk with a wanted id in a byte stream.
// A request is registered at acceptance; its result enters the output
// register when that request is processed, once the output register is free.
// Throughput: one byte per cycle; a waiting result holds the input register.
// Reset: arst_n clears the search state and sets the configuration registers to defaults.
// Depends on tcs_pkg, tcs_cfg_regs and tcs_search.
`default_nettype none
module tagged_chunk_search (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [tcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tcs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           item_valid,
	output logic                                item_ready,
	input  wire logic [7:0]                     data_byte,
	input  wire logic                           end_of_stream,
	output logic                                result_valid,
	input  wire logic                           result_ready,
	output logic [1:0]                          status,
	output logic [31:0]                         chunk_offset,
	output logic [31:0]                         chunk_len
);

	tcs_pkg::cfg_t    cfg;
	tcs_pkg::result_t res;

	logic        valid_s1;
	logic [7:0]  data_byte_s1;
	logic        eos_s1;
	logic        advance;
	logic        out_free;

	logic              valid_s2;
	tcs_pkg::status_t  status_s2;
	logic [31:0]       offset_s2;
	logic [31:0]       size_s2;

	tcs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tcs_search u_search (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.step          (advance),
		.data_byte     (data_byte_s1),
		.end_of_stream (eos_s1),
		.res           (res)
	);

	assign out_free   = !valid_s2 || result_ready;
	assign advance    = valid_s1 && out_free;
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			data_byte_s1 <= data_byte;
			eos_s1       <= end_of_stream;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= advance && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			status_s2 <= res.status;
			offset_s2 <= res.chunk_offset;
			size_s2   <= res.chunk_len;
		end
	end

	assign result_valid = valid_s2;
	assign status       = status_s2;
	assign chunk_offset = offset_s2;
	assign chunk_len    = size_s2;

`ifndef SYNTHESIS
	a_no_step_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> !valid_s2 || result_ready)
		else $error("byte processed while a result was blocked");

	a_result_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 ##1 valid_s2 |-> $past(advance) && $past(res.valid))
		else $error("result appeared without a processed byte");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(data_byte_s1)
			&& $stable(eos_s1))
		else $error("stalled byte lost from input register");
`endif

endmodule
`default_nettype wire
